/* rtl/core/mse_pkg.sv */
package mse_pkg;

  localparam int DATA_WORDS_DEF = 64;
  localparam int CODE_WORDS_DEF = 1024;

  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = 5;
  localparam int XLEN      = 32;

  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;
  localparam logic [5:0] OPC_BEQ     = 6'd4;
  localparam logic [5:0] OPC_BNE     = 6'd5;
  localparam logic [5:0] OPC_ADDI    = 6'd8;
  localparam logic [5:0] OPC_LW      = 6'd35;
  localparam logic [5:0] OPC_SW      = 6'd43;

  localparam logic [5:0] FN_SLL = 6'd0;
  localparam logic [5:0] FN_JR  = 6'd8;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;

  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic taken;
    logic reg_write;
    logic mem_write;
    logic mem_read;
    logic illegal;
  } mse_flags_t;

endpackage

/* rtl/core/mse_in_if.sv */
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink   (input valid, input instr, output ready);
endinterface

/* rtl/core/mse_out_if.sv */
interface mse_out_if #(
  parameter int PC_W = 10,
  parameter int MI_W = 6
);
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] next_pc;
  logic            branch_taken;
  logic            reg_write;
  logic [4:0]      reg_index;
  logic [31:0]     reg_value;
  logic            mem_write;
  logic            mem_read;
  logic [MI_W-1:0] mem_index;
  logic [31:0]     mem_value;
  logic            illegal;

  modport source (
    output valid, output next_pc, output branch_taken, output reg_write,
    output reg_index, output reg_value, output mem_write, output mem_read,
    output mem_index, output mem_value, output illegal, input ready
  );
  modport sink (
    input valid, input next_pc, input branch_taken, input reg_write,
    input reg_index, input reg_value, input mem_write, input mem_read,
    input mem_index, input mem_value, input illegal, output ready
  );
endinterface

/* rtl/core/mse_ram.sv */
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/mse_exec.sv */
module mse_exec #(
  parameter int CODE_WORDS = mse_pkg::CODE_WORDS_DEF,
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF,
  localparam int PC_W = $clog2(CODE_WORDS),
  localparam int MI_W = $clog2(DATA_WORDS)
) (
  input  logic [31:0]                  instr,
  input  logic [31:0]                  op_a,
  input  logic [31:0]                  op_b,
  input  logic [PC_W-1:0]              pc,
  output mse_pkg::mse_flags_t          flags,
  output logic [PC_W-1:0]              npc,
  output logic [mse_pkg::REG_IDX_W-1:0] widx,
  output logic [31:0]                  wval,
  output logic [MI_W-1:0]              midx,
  output logic [31:0]                  mval
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] addr_sum;
  logic [PC_W-1:0] seq;
  logic        wr;
  logic [mse_pkg::REG_IDX_W-1:0] idx;
  logic [31:0] val;

  assign opc      = instr[31:26];
  assign rt       = instr[20:16];
  assign rd       = instr[15:11];
  assign sh       = instr[10:6];
  assign fn       = instr[5:0];
  assign imm      = {{16{instr[15]}}, instr[15:0]};
  assign addr_sum = op_a + imm;
  assign seq      = pc + PC_W'(1);

  always_comb begin
    flags = '0;
    npc   = seq;
    wr    = 1'b0;
    idx   = '0;
    val   = '0;
    midx  = '0;
    mval  = '0;
    unique case (opc) inside
      mse_pkg::OPC_SPECIAL: begin
        wr  = 1'b1;
        idx = rd;
        unique case (fn)
          mse_pkg::FN_ADD: val = op_a + op_b;
          mse_pkg::FN_SUB: val = op_a - op_b;
          mse_pkg::FN_AND: val = op_a & op_b;
          mse_pkg::FN_OR:  val = op_a | op_b;
          mse_pkg::FN_SLT: val = {31'd0, $signed(op_a) < $signed(op_b)};
          mse_pkg::FN_SLL: val = op_b << sh;
          mse_pkg::FN_JR: begin
            wr          = 1'b0;
            npc         = op_a[PC_W-1:0];
            flags.taken = 1'b1;
          end
          default: begin
            wr            = 1'b0;
            flags.illegal = 1'b1;
          end
        endcase
      end
      mse_pkg::OPC_J: begin
        npc         = instr[PC_W-1:0];
        flags.taken = 1'b1;
      end
      mse_pkg::OPC_JAL: begin
        npc         = instr[PC_W-1:0];
        flags.taken = 1'b1;
        wr          = 1'b1;
        idx         = mse_pkg::LINK_REG;
        val         = {{(32-PC_W){1'b0}}, seq};
      end
      mse_pkg::OPC_BEQ, mse_pkg::OPC_BNE: begin
        if ((op_a == op_b) == (opc == mse_pkg::OPC_BEQ)) begin
          npc         = seq + imm[PC_W-1:0];
          flags.taken = 1'b1;
        end
      end
      mse_pkg::OPC_ADDI: begin
        wr  = 1'b1;
        idx = rt;
        val = addr_sum;
      end
      mse_pkg::OPC_LW: begin
        // loaded word arrives one stage later
        midx           = addr_sum[2 +: MI_W];
        flags.mem_read = 1'b1;
        wr             = 1'b1;
        idx            = rt;
      end
      mse_pkg::OPC_SW: begin
        midx            = addr_sum[2 +: MI_W];
        mval            = op_b;
        flags.mem_write = 1'b1;
      end
      default: flags.illegal = 1'b1;
    endcase

    flags.reg_write = wr && (idx != '0);
    widx = flags.reg_write ? idx : '0;
    wval = flags.reg_write ? val : '0;
  end

endmodule

/* rtl/core/mips_subset_instruction_executor.sv */
// MIPS32 integer subset executor, one instruction word per input beat, one
// result beat per instruction. Three stages: register file read as the word is
// taken, execute (ALU, branch, data address, data memory write), then the
// result register, where lw data comes out of the data memory. A new word is
// taken every cycle while results drain; a word goes through s2_instr_r and the
// s3 result registers, and results are forwarded between stages so back-to-back
// dependent instructions run at full rate. After reset a clearing pass over
// max(DATA_WORDS, 32) entries zeroes the register file and data memory; input
// ready stays low until it ends. CODE_WORDS and DATA_WORDS are powers of two.
module mips_subset_instruction_executor #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF,
  parameter int CODE_WORDS = mse_pkg::CODE_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mse_in_if.sink           in_bus,
  mse_out_if.source        out_bus
);

  localparam int PC_W      = $clog2(CODE_WORDS);
  localparam int MI_W      = $clog2(DATA_WORDS);
  localparam int RI_W      = mse_pkg::REG_IDX_W;
  localparam int CLR_WORDS = (DATA_WORDS > mse_pkg::REG_COUNT) ? DATA_WORDS
                                                               : mse_pkg::REG_COUNT;
  localparam int CLR_W     = $clog2(CLR_WORDS);

  logic             clearing_r;
  logic [CLR_W-1:0] clr_r;

  logic             s2_valid_r;
  logic [31:0]      s2_instr_r;
  logic [PC_W-1:0]  pc_r;

  logic                s3_valid_r;
  mse_pkg::mse_flags_t s3_flags_r;
  logic [PC_W-1:0]     s3_npc_r;
  logic [RI_W-1:0]     s3_widx_r;
  logic [31:0]         s3_wval_r;
  logic [MI_W-1:0]     s3_midx_r;
  logic [31:0]         s3_mval_r;

  logic            wb_valid_r;
  logic [RI_W-1:0] wb_idx_r;
  logic [31:0]     wb_val_r;

  logic adv;
  logic in_beat;
  logic retire;

  logic [31:0] rf_a_q;
  logic [31:0] rf_b_q;
  logic [31:0] dm_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] s3_val;
  logic        s3_wr;

  mse_pkg::mse_flags_t ex_flags;
  logic [PC_W-1:0]     ex_npc;
  logic [RI_W-1:0]     ex_widx;
  logic [31:0]         ex_wval;
  logic [MI_W-1:0]     ex_midx;
  logic [31:0]         ex_mval;

  logic            rf_we;
  logic [RI_W-1:0] rf_waddr;
  logic [31:0]     rf_wdata;
  logic            dm_we;
  logic [MI_W-1:0] dm_waddr;
  logic [31:0]     dm_wdata;

  assign adv     = !s3_valid_r || out_bus.ready;
  assign in_bus.ready = adv && !clearing_r;
  assign in_beat = in_bus.valid && in_bus.ready;
  assign retire  = s3_valid_r && out_bus.ready;

  assign s3_wr  = s3_valid_r && s3_flags_r.reg_write;
  assign s3_val = s3_flags_r.mem_read ? dm_q : s3_wval_r;

  function automatic logic [31:0] fwd(
    input logic [RI_W-1:0] idx,
    input logic [31:0]     ram_q,
    input logic            s3w,
    input logic [RI_W-1:0] s3i,
    input logic [31:0]     s3v,
    input logic            wbv,
    input logic [RI_W-1:0] wbi,
    input logic [31:0]     wbd
  );
    logic [31:0] r;
    if (s3w && s3i == idx) begin
      r = s3v;
    end else if (wbv && wbi == idx) begin
      r = wbd;
    end else begin
      r = ram_q;
    end
    return r;
  endfunction

  assign op_a = fwd(s2_instr_r[25:21], rf_a_q, s3_wr, s3_widx_r, s3_val,
                    wb_valid_r, wb_idx_r, wb_val_r);
  assign op_b = fwd(s2_instr_r[20:16], rf_b_q, s3_wr, s3_widx_r, s3_val,
                    wb_valid_r, wb_idx_r, wb_val_r);

  mse_exec #(
    .CODE_WORDS (CODE_WORDS),
    .DATA_WORDS (DATA_WORDS)
  ) u_exec (
    .instr (s2_instr_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .pc    (pc_r),
    .flags (ex_flags),
    .npc   (ex_npc),
    .widx  (ex_widx),
    .wval  (ex_wval),
    .midx  (ex_midx),
    .mval  (ex_mval)
  );

  // clearing pass writes zeros; shorter store just rewrites its entries
  assign rf_we    = clearing_r || (retire && s3_flags_r.reg_write);
  assign rf_waddr = clearing_r ? clr_r[RI_W-1:0] : s3_widx_r;
  assign rf_wdata = clearing_r ? '0 : s3_val;

  assign dm_we    = clearing_r || (adv && s2_valid_r && ex_flags.mem_write);
  assign dm_waddr = clearing_r ? clr_r[MI_W-1:0] : ex_midx;
  assign dm_wdata = clearing_r ? '0 : ex_mval;

  mse_ram #(
    .WIDTH (32),
    .DEPTH (mse_pkg::REG_COUNT)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (adv),
    .raddr (in_bus.instr[25:21]),
    .rdata (rf_a_q)
  );

  mse_ram #(
    .WIDTH (32),
    .DEPTH (mse_pkg::REG_COUNT)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (adv),
    .raddr (in_bus.instr[20:16]),
    .rdata (rf_b_q)
  );

  mse_ram #(
    .WIDTH (32),
    .DEPTH (DATA_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (adv),
    .raddr (ex_midx),
    .rdata (dm_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      wb_valid_r <= 1'b0;
      pc_r       <= '0;
    end else begin
      if (clearing_r) begin
        clr_r <= clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_WORDS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (adv) begin
        s2_valid_r <= in_beat;
        s3_valid_r <= s2_valid_r;
        // write landing on the same edge as the register file read
        wb_valid_r <= retire && s3_flags_r.reg_write;
        if (s2_valid_r) begin
          pc_r <= ex_npc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_instr_r <= in_bus.instr;
      s3_flags_r <= ex_flags;
      s3_npc_r   <= ex_npc;
      s3_widx_r  <= ex_widx;
      s3_wval_r  <= ex_wval;
      s3_midx_r  <= ex_midx;
      s3_mval_r  <= ex_mval;
      wb_idx_r   <= s3_widx_r;
      wb_val_r   <= s3_val;
    end
  end

  assign out_bus.valid        = s3_valid_r;
  assign out_bus.next_pc      = s3_npc_r;
  assign out_bus.branch_taken = s3_flags_r.taken;
  assign out_bus.reg_write    = s3_flags_r.reg_write;
  assign out_bus.reg_index    = s3_widx_r;
  assign out_bus.reg_value    = (s3_flags_r.mem_read && s3_flags_r.reg_write) ? dm_q
                                                                              : s3_wval_r;
  assign out_bus.mem_write    = s3_flags_r.mem_write;
  assign out_bus.mem_read     = s3_flags_r.mem_read;
  assign out_bus.mem_index    = s3_midx_r;
  assign out_bus.mem_value    = s3_flags_r.mem_read ? dm_q : s3_mval_r;
  assign out_bus.illegal      = s3_flags_r.illegal;

endmodule

/* bench/mips_subset_instruction_executor_tb.sv */
module mips_subset_instruction_executor_tb;
  import mse_pkg::*;

  localparam int PC_W           = $clog2(CODE_WORDS_DEF);
  localparam int MI_W           = $clog2(DATA_WORDS_DEF);
  localparam int RANDOM_ITEMS   = 625;
  localparam int DRAIN_AT       = 400;
  localparam int HOLD_AT        = 200;
  localparam int HOLD_CYCLES    = 120;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            branch_taken;
    logic            reg_write;
    logic [4:0]      reg_index;
    logic [31:0]     reg_value;
    logic            mem_write;
    logic            mem_read;
    logic [MI_W-1:0] mem_index;
    logic [31:0]     mem_value;
    logic            illegal;
  } retire_t;

  typedef struct {
    logic [31:0] word;
    int unsigned gap;
    bit          drain;
  } fetch_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mse_in_if in_ch ();
  mse_out_if #(.PC_W(PC_W), .MI_W(MI_W)) out_ch ();

  mips_subset_instruction_executor uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // architectural state of the predictor
  logic [PC_W-1:0] arch_pc = '0;
  logic [31:0]     gpr [REG_COUNT] = '{default: '0};
  logic [31:0]     dmem [DATA_WORDS_DEF] = '{default: '0};

  fetch_t      fetch_q[$];
  retire_t     retire_q[$];
  int unsigned bad_fields = 0;
  int unsigned retired = 0;
  int unsigned n_loads = 0;
  int unsigned n_stores = 0;
  int unsigned n_redirects = 0;
  int unsigned n_illegal = 0;

  function automatic retire_t exec_instr(input logic [31:0] w);
    retire_t         r;
    logic [5:0]      opc;
    logic [5:0]      fn;
    logic [4:0]      rs;
    logic [4:0]      rt;
    logic [4:0]      rd;
    logic [4:0]      sh;
    logic [31:0]     imm;
    logic [31:0]     a;
    logic [31:0]     b;
    logic [31:0]     ea;
    logic [PC_W-1:0] seq;
    opc = w[31:26];
    rs  = w[25:21];
    rt  = w[20:16];
    rd  = w[15:11];
    sh  = w[10:6];
    fn  = w[5:0];
    imm = {{16{w[15]}}, w[15:0]};
    a   = gpr[rs];
    b   = gpr[rt];
    ea  = a + imm;
    seq = arch_pc + 1'b1;
    r = '0;
    r.next_pc = seq;
    case (opc)
      OPC_SPECIAL: begin
        r.reg_write = 1'b1;
        r.reg_index = rd;
        case (fn)
          FN_ADD: r.reg_value = a + b;
          FN_SUB: r.reg_value = a - b;
          FN_AND: r.reg_value = a & b;
          FN_OR:  r.reg_value = a | b;
          FN_SLT: r.reg_value = {31'd0, $signed(a) < $signed(b)};
          FN_SLL: r.reg_value = b << sh;
          FN_JR: begin
            r.reg_write    = 1'b0;
            r.next_pc      = a[PC_W-1:0];
            r.branch_taken = 1'b1;
          end
          default: begin
            r.reg_write = 1'b0;
            r.illegal   = 1'b1;
          end
        endcase
      end
      OPC_J: begin
        r.next_pc      = w[PC_W-1:0];
        r.branch_taken = 1'b1;
      end
      OPC_JAL: begin
        r.next_pc      = w[PC_W-1:0];
        r.branch_taken = 1'b1;
        r.reg_write    = 1'b1;
        r.reg_index    = LINK_REG;
        r.reg_value    = 32'(seq);
      end
      OPC_BEQ, OPC_BNE: begin
        if ((a == b) == (opc == OPC_BEQ)) begin
          r.next_pc      = seq + imm[PC_W-1:0];
          r.branch_taken = 1'b1;
        end
      end
      OPC_ADDI: begin
        r.reg_write = 1'b1;
        r.reg_index = rt;
        r.reg_value = ea;
      end
      OPC_LW: begin
        r.mem_read  = 1'b1;
        r.mem_index = ea[MI_W+1:2];
        r.mem_value = dmem[ea[MI_W+1:2]];
        r.reg_write = 1'b1;
        r.reg_index = rt;
        r.reg_value = r.mem_value;
      end
      OPC_SW: begin
        r.mem_write = 1'b1;
        r.mem_index = ea[MI_W+1:2];
        r.mem_value = b;
        dmem[ea[MI_W+1:2]] = b;
      end
      default: r.illegal = 1'b1;
    endcase
    if (r.reg_write && r.reg_index == '0)
      r.reg_write = 1'b0;
    if (r.reg_write)
      gpr[r.reg_index] = r.reg_value;
    else begin
      r.reg_index = '0;
      r.reg_value = '0;
    end
    arch_pc = r.next_pc;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      bad_fields++;
    end
  endfunction

  // instruction encoders and random field helpers
  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {OPC_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [4:0] rand_reg();
    return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'($urandom_range(0, 32)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] gen_word();
    int unsigned sel;
    logic [5:0]  fn;
    logic [4:0]  base;
    logic [15:0] off;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      case ($urandom_range(0, 5))
        0: fn = FN_ADD;
        1: fn = FN_SUB;
        2: fn = FN_AND;
        3: fn = FN_OR;
        4: fn = FN_SLT;
        default: fn = FN_SLL;
      endcase
      return enc_r(rand_reg(), rand_reg(), rand_reg(), 5'($urandom_range(0, 31)), fn);
    end
    if (sel < 45)
      return enc_i(OPC_ADDI, rand_reg(), rand_reg(), rand_imm());
    if (sel < 69) begin
      if ($urandom_range(0, 1) != 0) begin
        base = '0;
        off  = 16'($urandom_range(0, 255));
      end else begin
        base = rand_reg();
        off  = rand_imm();
      end
      return enc_i((sel < 57) ? OPC_LW : OPC_SW, base, rand_reg(), off);
    end
    if (sel < 79)
      return enc_i(($urandom_range(0, 1) != 0) ? OPC_BEQ : OPC_BNE, rand_reg(), rand_reg(),
                   rand_imm());
    if (sel < 85)
      return {(($urandom_range(0, 1) != 0) ? OPC_J : OPC_JAL), 26'($urandom)};
    if (sel < 88)
      return enc_r(rand_reg(), 5'($urandom), 5'($urandom), 5'($urandom), FN_JR);
    if (sel < 94) begin
      do
        fn = 6'($urandom);
      while (fn inside {FN_SLL, FN_JR, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT});
      return enc_r(rand_reg(), rand_reg(), rand_reg(), 5'($urandom), fn);
    end
    return $urandom;
  endfunction

  function automatic void queue_word(input logic [31:0] w);
    fetch_t      it;
    int unsigned idx;
    idx = fetch_q.size();
    it.word  = w;
    it.drain = (idx == DRAIN_AT);
    if ((idx >= 150 && idx < 260) || (idx >= 480 && idx < 540))
      it.gap = 0;
    else
      it.gap = $urandom_range(0, 9);
    fetch_q.push_back(it);
  endfunction

  // driver: offers queued words, counts beats on both sides for the drain pause
  int unsigned gap_cnt;
  bit          gap_armed;
  int unsigned sent_n;
  int unsigned got_n;

  always @(posedge clk) begin
    logic        offer;
    logic [31:0] word;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.instr <= '0;
      gap_cnt   = 0;
      gap_armed = 1'b0;
      sent_n    = 0;
      got_n     = 0;
    end else begin
      offer = in_ch.valid;
      word  = in_ch.instr;
      if (out_ch.valid && out_ch.ready)
        got_n++;
      if (in_ch.valid && in_ch.ready) begin
        offer = 1'b0;
        sent_n++;
      end
      if (!offer) begin
        if (gap_cnt != 0)
          gap_cnt--;
        else if (fetch_q.size() != 0 && (!fetch_q[0].drain || sent_n == got_n)) begin
          if (!gap_armed && fetch_q[0].gap != 0) begin
            gap_cnt   = fetch_q[0].gap - 1;
            gap_armed = 1'b1;
          end else begin
            word      = fetch_q.pop_front().word;
            offer     = 1'b1;
            gap_armed = 1'b0;
          end
        end
      end
      in_ch.valid <= offer;
      in_ch.instr <= word;
    end
  end

  // monitor: checks result beats, then predicts for the instruction taken this edge
  int unsigned stall_cnt;

  always @(posedge clk) begin
    retire_t want;
    retire_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.next_pc, out_ch.branch_taken, out_ch.reg_write, out_ch.reg_index,
                out_ch.reg_value, out_ch.mem_write, out_ch.mem_read, out_ch.mem_index,
                out_ch.mem_value, out_ch.illegal};
        if (retire_q.size() == 0) begin
          $error("result beat with no instruction outstanding");
          bad_fields++;
        end else begin
          want = retire_q.pop_front();
          check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
          check_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
          check_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
          check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
          check_field("reg_value", want.reg_value, got.reg_value);
          check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
          check_field("mem_read", 32'(want.mem_read), 32'(got.mem_read));
          check_field("mem_index", 32'(want.mem_index), 32'(got.mem_index));
          check_field("mem_value", want.mem_value, got.mem_value);
          check_field("illegal", 32'(want.illegal), 32'(got.illegal));
          n_loads     += want.mem_read;
          n_stores    += want.mem_write;
          n_redirects += want.branch_taken;
          n_illegal   += want.illegal;
        end
        retired++;
        if (retired == HOLD_AT)
          stall_cnt = HOLD_CYCLES;
        else if ((retired >= 300 && retired < 380) || (retired >= 550 && retired < 600))
          stall_cnt = 0;
        else
          stall_cnt = $urandom_range(0, 9);
      end else if (stall_cnt != 0)
        stall_cnt--;
      if (in_ch.valid && in_ch.ready)
        retire_q.push_back(exec_instr(in_ch.instr));
      out_ch.ready <= (stall_cnt == 0);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("mips_subset_instruction_executor: mismatch");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int unsigned n;
    in_ch.valid  = 1'b0;
    in_ch.instr  = '0;
    out_ch.ready = 1'b0;

    queue_word(enc_i(OPC_ADDI, 5'd0, 5'd1, 16'h7FFF));
    queue_word(enc_i(OPC_ADDI, 5'd0, 5'd2, 16'h8000));
    queue_word(enc_i(OPC_ADDI, 5'd0, 5'd3, 16'hFFFF));
    queue_word(enc_r(5'd17, 5'd3, 5'd4, 5'd31, FN_SLL));   // rs field ignored
    queue_word(enc_r(5'd4, 5'd3, 5'd5, 5'd0, FN_ADD));     // wraps
    queue_word(enc_r(5'd4, 5'd1, 5'd6, 5'd0, FN_SUB));
    queue_word(enc_r(5'd3, 5'd1, 5'd7, 5'd0, FN_AND));
    queue_word(enc_r(5'd2, 5'd1, 5'd8, 5'd0, FN_OR));
    queue_word(enc_r(5'd4, 5'd1, 5'd9, 5'd0, FN_SLT));     // signed compare
    queue_word(enc_r(5'd1, 5'd4, 5'd10, 5'd0, FN_SLT));
    queue_word(enc_r(5'd3, 5'd3, 5'd0, 5'd0, FN_ADD));     // r0 write dropped
    queue_word(enc_i(OPC_SW, 5'd3, 5'd3, 16'h7FFF));       // address wraps to top word
    queue_word(enc_i(OPC_LW, 5'd3, 5'd11, 16'h7FFF));
    queue_word(enc_i(OPC_LW, 5'd0, 5'd0, 16'h8000));
    queue_word(enc_i(OPC_SW, 5'd0, 5'd1, 16'h0000));
    queue_word(enc_i(OPC_LW, 5'd0, 5'd12, 16'h0003));      // byte bits dropped
    queue_word(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'hFFFF));
    queue_word(enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h0010));
    queue_word(enc_i(OPC_BNE, 5'd1, 5'd2, 16'h7FFF));
    queue_word(enc_i(OPC_BNE, 5'd3, 5'd3, 16'h8000));
    queue_word({OPC_J, 26'h3FF_FFFF});                     // top of code space
    queue_word({OPC_JAL, 26'h000_0000});                   // pc wraps, link gets 0
    queue_word(enc_r(5'd3, 5'd9, 5'd14, 5'd7, FN_JR));
    queue_word(enc_r(5'd1, 5'd2, 5'd3, 5'd0, 6'd1));
    queue_word(32'hFC00_1234);
    for (n = 0; n < RANDOM_ITEMS; n++)
      queue_word(gen_word());
    n = fetch_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (fetch_q.size() != 0 || in_ch.valid === 1'b1)
      @(posedge clk);
    while (retire_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d of %0d instructions retired: %0d loads, %0d stores, %0d redirects, %0d illegal",
             retired, n, n_loads, n_stores, n_redirects, n_illegal);
    $display("with random gaps both sides, one %0d-cycle output hold and one full drain",
             HOLD_CYCLES);
    if (bad_fields == 0 && retire_q.size() == 0)
      $display("mips_subset_instruction_executor: match");
    else
      $display("mips_subset_instruction_executor: mismatch");
    $finish;
  end

endmodule
